>>> src/arpc_pkg.sv
// ----------------------------------------------------------------------------
// ARP reply classifier package
// Shared types, widths and verdict codes.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

  localparam int MAC_W   = 48;
  localparam int IP_W    = 32;
  localparam int POS_W   = 6;
  localparam int VERD_W  = 2;
  localparam int CIDX_W  = 1;

  localparam logic [POS_W-1:0] FRAME_LEN     = 6'd42;
  localparam logic [POS_W-1:0] MAC_LEN       = 6'd6;
  localparam logic [POS_W-1:0] SRC_END       = 6'd12;
  localparam logic [POS_W-1:0] POS_PROTO_HI  = 6'd16;
  localparam logic [POS_W-1:0] POS_PROTO_LO  = 6'd17;
  localparam logic [POS_W-1:0] POS_HLEN      = 6'd18;
  localparam logic [POS_W-1:0] POS_PLEN      = 6'd19;
  localparam logic [POS_W-1:0] POS_OP_HI     = 6'd20;
  localparam logic [POS_W-1:0] POS_OP_LO     = 6'd21;
  localparam logic [POS_W-1:0] POS_SIP_FIRST = 6'd28;
  localparam logic [POS_W-1:0] POS_SIP_END   = 6'd32;

  localparam logic [15:0] PROTO_IPV4 = 16'h0800;
  localparam logic [15:0] PROTO_ALT  = 16'h1000;
  localparam logic [7:0]  HLEN_ETH   = 8'd6;
  localparam logic [7:0]  PLEN_IPV4  = 8'd4;
  localparam logic [7:0]  OP_HI      = 8'd0;
  localparam logic [7:0]  OP_REPLY   = 8'd2;

  localparam logic [CIDX_W-1:0] REG_OWN_MAC  = 1'd0;
  localparam logic [CIDX_W-1:0] REG_PROBE_IP = 1'd1;

  localparam logic [VERD_W-1:0] VERDICT_IGNORE = 2'd0;
  localparam logic [VERD_W-1:0] VERDICT_SELF   = 2'd1;
  localparam logic [VERD_W-1:0] VERDICT_REPLY  = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic              valid;
    logic [VERD_W-1:0] verdict;
  } result_t;

  function automatic logic [7:0] mac_byte(input logic [MAC_W-1:0] mac,
                                          input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = mac[47:40];
      3'd1: b = mac[39:32];
      3'd2: b = mac[31:24];
      3'd3: b = mac[23:16];
      3'd4: b = mac[15:8];
      3'd5: b = mac[7:0];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] ip_byte(input logic [IP_W-1:0] ip,
                                         input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0: b = ip[31:24];
      2'd1: b = ip[23:16];
      2'd2: b = ip[15:8];
      2'd3: b = ip[7:0];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> src/arp_reply_frame_classifier.sv
// ----------------------------------------------------------------------------
// ARP reply frame classifier
// Checks a byte-wide Ethernet frame for an ARP reply to a probed address.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle on the frame channel and returns one verdict
// beat per frame, on the byte flagged last: 0 ignore, 1 answered by this
// station, 2 valid ARP reply. Each byte passes an input register, one level of
// compare and flag update, and the verdict output register. Bytes are taken every
// cycle; only a last byte that meets a held, stalled verdict waits. Write the
// station MAC (index 0) and probed IPv4 address (index 1) between frames.
`default_nettype none

module arp_reply_frame_classifier (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        frame_valid,
  output logic                             frame_stall,
  input  wire logic [7:0]                  frame_byte,
  input  wire logic                        frame_last,
  output logic                             verdict_valid,
  input  wire logic                        verdict_stall,
  output logic      [arpc_pkg::VERD_W-1:0] verdict,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [arpc_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [arpc_pkg::MAC_W-1:0]  cfg_data
);
  import arpc_pkg::*;

  logic              beat_valid;
  beat_t             beat;
  logic              advance;
  result_t           result;
  logic [MAC_W-1:0]  own_mac;
  logic [IP_W-1:0]   probe_ip;

  assign frame_stall = beat_valid && beat.last && verdict_valid && verdict_stall;
  assign advance     = beat_valid && !frame_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (!frame_stall) begin
      beat_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!frame_stall) begin
      beat.data <= frame_byte;
      beat.last <= frame_last;
    end
  end

  arpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .own_mac   (own_mac),
    .probe_ip  (probe_ip)
  );

  arpc_frame_check u_check (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .beat     (beat),
    .own_mac  (own_mac),
    .probe_ip (probe_ip),
    .result   (result)
  );

  arpc_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .result        (result),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .verdict       (verdict)
  );

endmodule

`default_nettype wire

>>> src/arpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// ARP reply classifier configuration registers
// Holds the station MAC and the probed IPv4 address.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [arpc_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [arpc_pkg::MAC_W-1:0]  cfg_data,
  output logic      [arpc_pkg::MAC_W-1:0]  own_mac,
  output logic      [arpc_pkg::IP_W-1:0]   probe_ip
);
  import arpc_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac  <= '0;
      probe_ip <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OWN_MAC:  own_mac  <= cfg_data;
        REG_PROBE_IP: probe_ip <= cfg_data[IP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/arpc_frame_check.sv
// ----------------------------------------------------------------------------
// ARP reply classifier frame check
// Tracks byte position and sticky mismatch flags, forms the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_frame_check (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       advance,
  input  wire arpc_pkg::beat_t            beat,
  input  wire logic [arpc_pkg::MAC_W-1:0] own_mac,
  input  wire logic [arpc_pkg::IP_W-1:0]  probe_ip,
  output arpc_pkg::result_t               result
);
  import arpc_pkg::*;

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       proto_high_byte, proto_high_byte_next;
  logic             header_bad, header_bad_next;
  logic             sender_ip_differs, sender_ip_differs_next;
  logic             dest_mac_differs, dest_mac_differs_next;
  logic             source_mac_differs, source_mac_differs_next;
  logic [POS_W-1:0] src_idx;
  logic [15:0]      proto;

  assign src_idx = byte_position - MAC_LEN;
  assign proto   = {proto_high_byte, beat.data};

  always_comb begin
    byte_position_next      = byte_position;
    proto_high_byte_next    = proto_high_byte;
    header_bad_next         = header_bad;
    sender_ip_differs_next  = sender_ip_differs;
    dest_mac_differs_next   = dest_mac_differs;
    source_mac_differs_next = source_mac_differs;
    if (byte_position < FRAME_LEN) begin
      byte_position_next = byte_position + 1'b1;
      if (byte_position < MAC_LEN) begin
        if (beat.data != mac_byte(own_mac, byte_position[2:0])) dest_mac_differs_next = 1'b1;
      end else if (byte_position < SRC_END) begin
        if (beat.data != mac_byte(own_mac, src_idx[2:0])) source_mac_differs_next = 1'b1;
      end else if (byte_position == POS_PROTO_HI) begin
        proto_high_byte_next = beat.data;
      end else if (byte_position == POS_PROTO_LO) begin
        if (proto != PROTO_IPV4 && proto != PROTO_ALT) header_bad_next = 1'b1;
      end else if (byte_position == POS_HLEN) begin
        if (beat.data != HLEN_ETH) header_bad_next = 1'b1;
      end else if (byte_position == POS_PLEN) begin
        if (beat.data != PLEN_IPV4) header_bad_next = 1'b1;
      end else if (byte_position == POS_OP_HI) begin
        if (beat.data != OP_HI) header_bad_next = 1'b1;
      end else if (byte_position == POS_OP_LO) begin
        if (beat.data != OP_REPLY) header_bad_next = 1'b1;
      end else if (byte_position >= POS_SIP_FIRST && byte_position < POS_SIP_END) begin
        if (beat.data != ip_byte(probe_ip, byte_position[1:0])) sender_ip_differs_next = 1'b1;
      end
    end
  end

  always_comb begin
    result.valid = advance && beat.last;
    if (byte_position_next < FRAME_LEN || header_bad_next || sender_ip_differs_next) begin
      result.verdict = VERDICT_IGNORE;
    end else if (!source_mac_differs_next) begin
      result.verdict = VERDICT_SELF;
    end else if (dest_mac_differs_next) begin
      result.verdict = VERDICT_IGNORE;
    end else begin
      result.verdict = VERDICT_REPLY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && beat.last)) begin
      byte_position      <= '0;
      proto_high_byte    <= '0;
      header_bad         <= 1'b0;
      sender_ip_differs  <= 1'b0;
      dest_mac_differs   <= 1'b0;
      source_mac_differs <= 1'b0;
    end else if (advance) begin
      byte_position      <= byte_position_next;
      proto_high_byte    <= proto_high_byte_next;
      header_bad         <= header_bad_next;
      sender_ip_differs  <= sender_ip_differs_next;
      dest_mac_differs   <= dest_mac_differs_next;
      source_mac_differs <= source_mac_differs_next;
    end
  end

endmodule

`default_nettype wire

>>> src/arpc_out_reg.sv
// ----------------------------------------------------------------------------
// ARP reply classifier output register
// Holds one verdict beat until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_out_reg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire arpc_pkg::result_t           result,
  output logic                             verdict_valid,
  input  wire logic                        verdict_stall,
  output logic      [arpc_pkg::VERD_W-1:0] verdict
);
  import arpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (result.valid) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      verdict <= result.verdict;
    end
  end

endmodule

`default_nettype wire

>>> src/arpc_checker.sv
// ----------------------------------------------------------------------------
// ARP reply classifier port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        frame_valid,
  input  wire logic                        frame_stall,
  input  wire logic                        frame_last,
  input  wire logic                        verdict_valid,
  input  wire logic                        verdict_stall,
  input  wire logic [arpc_pkg::VERD_W-1:0] verdict
);
  import arpc_pkg::*;

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |-> (verdict == VERDICT_IGNORE || verdict == VERDICT_SELF ||
                       verdict == VERDICT_REPLY))
    else $error("verdict code out of range");

  a_rose_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(verdict_valid) |-> $past(frame_valid && !frame_stall && frame_last, 2))
    else $error("verdict beat without a last frame beat");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    frame_stall |-> (verdict_valid && verdict_stall))
    else $error("frame stalled while verdict side is free");

  a_verdict_hold: assert property (@(posedge clk) disable iff (rst)
    (verdict_valid && verdict_stall) |=> (verdict_valid && $stable(verdict)))
    else $error("stalled verdict beat changed");

endmodule

bind arp_reply_frame_classifier arpc_checker u_arpc_checker (
  .clk           (clk),
  .rst           (rst),
  .frame_valid   (frame_valid),
  .frame_stall   (frame_stall),
  .frame_last    (frame_last),
  .verdict_valid (verdict_valid),
  .verdict_stall (verdict_stall),
  .verdict       (verdict)
);

`default_nettype wire
